// ----- rtl/ddmr_pkg.sv -----
// ----------------------------------------------------------------------------
// ddmr_pkg
// Shared types, widths and constants for the differential drive mixer.
// ----------------------------------------------------------------------------
package ddmr_pkg;

  // fixed point format of commands and drive levels
  localparam int FRAC_BITS = 14;
  localparam int CMD_W     = 16;
  localparam int SUM_W     = CMD_W + 1;
  localparam int LVL_W     = CMD_W;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int unsigned ONE_INT = 1 << FRAC_BITS;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE       = 3'd4;

  localparam logic [CFG_DATA_W-1:0] DEADZONE_RST  = 15'd819;
  localparam logic [CFG_DATA_W-1:0] THR_LIMIT_RST = 15'd16384;
  localparam logic [CFG_DATA_W-1:0] YAW_LIMIT_RST = 15'd16384;
  localparam logic [CFG_DATA_W-1:0] RAMP_STEP_RST = 15'd328;

  // mixing modes
  localparam logic MODE_SCALE    = 1'b0;
  localparam logic MODE_PRIORITY = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIV,
    ST_FIN
  } ddmr_state_t;

endpackage

// ----- rtl/differential_drive_mixer_ramp_top.sv -----
// Flow: the input beat is captured, mixed, divided when mode 0 must scale
//   down, and slewed into the output register; the scale-down runs a shared
//   restoring divider, one quotient bit per cycle, for the left target and
//   again for the right. One item is in flight at a time; a new beat is taken
//   while the previous result still waits in the output register.
// Reset: synchronous active low; configuration registers return to defaults, levels to zero.
// ----------------------------------------------------------------------------
// differential_drive_mixer_ramp_top
// Throttle/yaw to left/right drive mixer with deadzone, limits and slew limit.
// ----------------------------------------------------------------------------
module differential_drive_mixer_ramp_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ddmr_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [ddmr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ddmr_pkg::CMD_W-1:0]      in_throttle_cmd,
  input  logic signed [ddmr_pkg::CMD_W-1:0]      in_yaw_cmd,
  input  logic                                   in_link_failsafe,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ddmr_pkg::LVL_W-1:0]      out_left_drive,
  output logic signed [ddmr_pkg::LVL_W-1:0]      out_right_drive,
  output logic                                   out_stopped
);

  localparam logic [ddmr_pkg::SUM_W-1:0] ONE = ddmr_pkg::SUM_W'(ddmr_pkg::ONE_INT);
  localparam logic [ddmr_pkg::CNT_W-1:0] CNT_LAST = ddmr_pkg::CNT_W'(ddmr_pkg::QUO_W - 1);

  // configuration registers
  logic [ddmr_pkg::CFG_DATA_W-1:0] dz_r, tlim_r, ylim_r, ramp_r;
  logic                            mode_r;

  // sequencer and datapath registers
  ddmr_pkg::ddmr_state_t           state_r, state_nxt;
  logic signed [ddmr_pkg::CMD_W-1:0] thr_r, yaw_r;
  logic                            fs_r;
  logic signed [ddmr_pkg::SUM_W-1:0] l_r, l_nxt, r_r, r_nxt;
  logic [ddmr_pkg::SUM_W-1:0]      lmag_r, lmag_nxt, rmag_r, rmag_nxt;
  logic [ddmr_pkg::SUM_W-1:0]      den_r, den_nxt;
  logic [ddmr_pkg::SUM_W-1:0]      rem_r, rem_nxt;
  logic [ddmr_pkg::QUO_W-1:0]      quo_r, quo_nxt;
  logic [ddmr_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            sel_r, sel_nxt;
  logic signed [ddmr_pkg::LVL_W-1:0] lvl_l_r, lvl_l_nxt, lvl_r_r, lvl_r_nxt;
  logic signed [ddmr_pkg::LVL_W-1:0] out_l_r, out_l_nxt, out_r_r, out_r_nxt;
  logic                            out_stop_r, out_stop_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // mix stage signals
  logic signed [ddmr_pkg::CMD_W-1:0] t_s, y_s;
  logic signed [ddmr_pkg::SUM_W-1:0] l0, r0, l1, r1, y1;
  logic [ddmr_pkg::SUM_W-1:0]      ml, mr, m;
  logic [ddmr_pkg::SUM_W-1:0]      tmag;
  logic signed [ddmr_pkg::SUM_W:0] room, yx, ycl;
  logic                            need_div;

  // divider signals
  logic [ddmr_pkg::SUM_W:0]        trial, diff;
  logic                            ge, div_done, fin_go;
  logic [ddmr_pkg::QUO_W-1:0]      q_fin;
  logic signed [ddmr_pkg::SUM_W-1:0] q_sgn;

  // deadzone then symmetric clamp
  function automatic logic signed [ddmr_pkg::CMD_W-1:0] shape(
    input logic signed [ddmr_pkg::CMD_W-1:0] v,
    input logic [ddmr_pkg::CFG_DATA_W-1:0]   dz,
    input logic [ddmr_pkg::CFG_DATA_W-1:0]   lim
  );
    logic signed [ddmr_pkg::SUM_W-1:0] vx, dzx, limx, w;
    vx   = ddmr_pkg::SUM_W'(v);
    dzx  = signed'({2'b00, dz});
    limx = signed'({2'b00, lim});
    w    = vx;
    if (vx > -dzx && vx < dzx) begin
      w = '0;
    end
    if (w < -limx) begin
      w = -limx;
    end else if (w > limx) begin
      w = limx;
    end
    return w[ddmr_pkg::CMD_W-1:0];
  endfunction

  // magnitude of a mixed sum
  function automatic logic [ddmr_pkg::SUM_W-1:0] magn(
    input logic signed [ddmr_pkg::SUM_W-1:0] v
  );
    return v[ddmr_pkg::SUM_W-1] ? ddmr_pkg::SUM_W'(-v) : ddmr_pkg::SUM_W'(v);
  endfunction

  // move one level toward its target, then saturate
  function automatic logic signed [ddmr_pkg::LVL_W-1:0] slew(
    input logic signed [ddmr_pkg::LVL_W-1:0] cur,
    input logic signed [ddmr_pkg::SUM_W-1:0] tgt,
    input logic [ddmr_pkg::CFG_DATA_W-1:0]   s
  );
    logic signed [ddmr_pkg::SUM_W:0] c, sx, hi, lo, tx, n;
    c  = (ddmr_pkg::SUM_W + 1)'(cur);
    sx = signed'({3'b000, s});
    hi = c + sx;
    lo = c - sx;
    tx = (ddmr_pkg::SUM_W + 1)'(tgt);
    priority if (tx > hi) begin
      n = hi;
    end else if (tx < lo) begin
      n = lo;
    end else begin
      n = tx;
    end
    if (n > (ddmr_pkg::SUM_W + 1)'(32767)) begin
      n = (ddmr_pkg::SUM_W + 1)'(32767);
    end else if (n < -(ddmr_pkg::SUM_W + 1)'(32768)) begin
      n = -(ddmr_pkg::SUM_W + 1)'(32768);
    end
    return n[ddmr_pkg::LVL_W-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r   <= ddmr_pkg::DEADZONE_RST;
      tlim_r <= ddmr_pkg::THR_LIMIT_RST;
      ylim_r <= ddmr_pkg::YAW_LIMIT_RST;
      ramp_r <= ddmr_pkg::RAMP_STEP_RST;
      mode_r <= ddmr_pkg::MODE_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ddmr_pkg::REG_DEADZONE:       dz_r   <= cfg_wdata;
        ddmr_pkg::REG_THROTTLE_LIMIT: tlim_r <= cfg_wdata;
        ddmr_pkg::REG_YAW_LIMIT:      ylim_r <= cfg_wdata;
        ddmr_pkg::REG_RAMP_STEP:      ramp_r <= cfg_wdata;
        ddmr_pkg::REG_MIX_MODE:       mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ddmr_pkg::ST_IDLE);

  // input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      thr_r <= in_throttle_cmd;
      yaw_r <= in_yaw_cmd;
      fs_r  <= in_link_failsafe;
    end
  end

  // shaping and both mixing laws
  always_comb begin
    t_s  = shape(thr_r, dz_r, tlim_r);
    y_s  = shape(yaw_r, dz_r, ylim_r);
    l0   = ddmr_pkg::SUM_W'(t_s) + ddmr_pkg::SUM_W'(y_s);
    r0   = ddmr_pkg::SUM_W'(t_s) - ddmr_pkg::SUM_W'(y_s);
    ml   = magn(l0);
    mr   = magn(r0);
    m    = (ml > mr) ? ml : mr;
    need_div = (mode_r == ddmr_pkg::MODE_SCALE) && (m > ONE);
    tmag = magn(ddmr_pkg::SUM_W'(t_s));
    room = signed'({1'b0, ONE}) - signed'({1'b0, tmag});
    if (room < 0) begin
      room = '0;
    end
    yx  = (ddmr_pkg::SUM_W + 1)'(y_s);
    priority if (yx > room) begin
      ycl = room;
    end else if (yx < -room) begin
      ycl = -room;
    end else begin
      ycl = yx;
    end
    y1 = ycl[ddmr_pkg::SUM_W-1:0];
    l1 = ddmr_pkg::SUM_W'(t_s) + y1;
    r1 = ddmr_pkg::SUM_W'(t_s) - y1;
  end

  // shared restoring divide step
  always_comb begin
    trial    = (cnt_r == '0) ? {1'b0, (sel_r ? rmag_r : lmag_r)} : {rem_r, 1'b0};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    q_fin    = {quo_r[ddmr_pkg::QUO_W-2:0], ge};
    q_sgn    = signed'(ddmr_pkg::SUM_W'(q_fin));
    div_done = (cnt_r == CNT_LAST);
    fin_go   = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ddmr_pkg::ST_IDLE: if (in_valid) state_nxt = ddmr_pkg::ST_MIX;
      ddmr_pkg::ST_MIX: begin
        if (fs_r || !need_div) state_nxt = ddmr_pkg::ST_FIN;
        else                   state_nxt = ddmr_pkg::ST_DIV;
      end
      ddmr_pkg::ST_DIV: if (div_done && sel_r) state_nxt = ddmr_pkg::ST_FIN;
      ddmr_pkg::ST_FIN: if (fin_go) state_nxt = ddmr_pkg::ST_IDLE;
      default: state_nxt = ddmr_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    l_nxt         = l_r;
    r_nxt         = r_r;
    lmag_nxt      = lmag_r;
    rmag_nxt      = rmag_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    lvl_l_nxt     = lvl_l_r;
    lvl_r_nxt     = lvl_r_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    out_stop_nxt  = out_stop_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ddmr_pkg::ST_IDLE: ;
      ddmr_pkg::ST_MIX: begin
        lmag_nxt = ml;
        rmag_nxt = mr;
        den_nxt  = m;
        cnt_nxt  = '0;
        sel_nxt  = 1'b0;
        quo_nxt  = '0;
        if (mode_r == ddmr_pkg::MODE_SCALE) begin
          l_nxt = l0;
          r_nxt = r0;
        end else begin
          l_nxt = l1;
          r_nxt = r1;
        end
      end
      ddmr_pkg::ST_DIV: begin
        rem_nxt = ge ? diff[ddmr_pkg::SUM_W-1:0] : trial[ddmr_pkg::SUM_W-1:0];
        quo_nxt = q_fin;
        cnt_nxt = cnt_r + 1'b1;
        if (div_done) begin
          cnt_nxt = '0;
          quo_nxt = '0;
          sel_nxt = 1'b1;
          if (sel_r) begin
            r_nxt = r_r[ddmr_pkg::SUM_W-1] ? -q_sgn : q_sgn;
          end else begin
            l_nxt = l_r[ddmr_pkg::SUM_W-1] ? -q_sgn : q_sgn;
          end
        end
      end
      ddmr_pkg::ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          if (fs_r) begin
            lvl_l_nxt    = '0;
            lvl_r_nxt    = '0;
            out_l_nxt    = '0;
            out_r_nxt    = '0;
            out_stop_nxt = 1'b1;
          end else begin
            lvl_l_nxt    = slew(lvl_l_r, l_r, ramp_r);
            lvl_r_nxt    = slew(lvl_r_r, r_r, ramp_r);
            out_l_nxt    = lvl_l_nxt;
            out_r_nxt    = lvl_r_nxt;
            out_stop_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddmr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      lvl_l_r     <= '0;
      lvl_r_r     <= '0;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_l_r     <= lvl_l_nxt;
      lvl_r_r     <= lvl_r_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    lmag_r     <= lmag_nxt;
    rmag_r     <= rmag_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_l_r    <= out_l_nxt;
    out_r_r    <= out_r_nxt;
    out_stop_r <= out_stop_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_l_r;
  assign out_right_drive = out_r_r;
  assign out_stopped     = out_stop_r;

endmodule

// ----- rtl/ddmr_chk.sv -----
// ----------------------------------------------------------------------------
// ddmr_chk
// Port-level checks for the differential drive mixer, bound to the top level.
// ----------------------------------------------------------------------------
module ddmr_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ddmr_pkg::LVL_W-1:0] out_left_drive,
  input logic signed [ddmr_pkg::LVL_W-1:0] out_right_drive,
  input logic                              out_stopped
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_drive) &&
      $stable(out_right_drive) && $stable(out_stopped))
    else $error("result beat changed while stalled");

  // a failsafe result drives both sides to zero
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> out_left_drive == '0 && out_right_drive == '0)
    else $error("stopped result with nonzero drive");

  // one item at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind differential_drive_mixer_ramp_top ddmr_chk u_ddmr_chk (.*);
